>>> hdl/mbm_pkg.sv
// Package with shared types and constants for the Modbus RTU master.
package mbm_pkg;
  localparam logic [7:0] FC_READ = 8'h03;
  localparam logic [7:0] FC_WRITE = 8'h06;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [1:0] FUNC_READ = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_BYTE = 2'd2;
  localparam logic [1:0] KIND_TX = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_COUNT = 3'd1;
  localparam logic [2:0] ST_HEADER = 3'd2;
  localparam logic [2:0] ST_LENGTH = 3'd3;
  localparam logic [2:0] ST_CRC = 3'd4;

  typedef struct packed {
    logic start;
    logic [15:0] init;
    logic [7:0] data;
  } crc_cmd_t;
endpackage

>>> hdl/modbus_rtu_master_fc03_fc06.sv
// Top level of the Modbus RTU master for read (FC03) and write (FC06) requests.
// Input beats (valid/stall): func 0 starts a read, func 1 a write, func 2
// carries one response byte with rx_end on the last byte of the frame.
// A request gives eight transmit-byte beats, the last with last set. Each of
// the six body bytes is loaded into the bit-serial CRC unit, folded in there
// and then handed over as a beat. The two CRC bytes are handed over without
// a pass through the unit, and the block then returns to idle; the input
// stays stalled for the whole request.
// The first two bytes of a response keep the input stalled only while they
// are stored; later bytes also wait for their CRC step. The end byte adds a
// step for the checks. A good read then drains the stored words, and every
// response ends with a status beat with last set.
// A read with count 0 or above MAX_REGS gives one status beat only.
// The block accepts one input beat at a time and holds it until all its
// results are taken. A stall on the output freezes the held result beat
// and the sequencer behind it; nothing is lost.
// Reset returns the block to idle with no pending transaction.
module modbus_rtu_master_fc03_fc06 import mbm_pkg::*; #(
  parameter int MAX_REGS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] func,
  input  logic [7:0] slave_addr,
  input  logic [15:0] reg_number,
  input  logic [15:0] word_value,
  input  logic [7:0] rx_byte,
  input  logic rx_end,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [15:0] out_word,
  output logic [4:0] word_index,
  output logic [2:0] status,
  output logic last
);
  localparam int CW = $clog2(MAX_REGS + 1);
  localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam logic [3:0] S_IDLE = 4'd0, S_TXC = 4'd1, S_TXW = 4'd2, S_TXO = 4'd3,
    S_RXC = 4'd4, S_RXW = 4'd5, S_END = 4'd6, S_DRAIN = 4'd7, S_DOUT = 4'd8,
    S_STAT = 4'd9, S_RD = 4'd10;
  localparam logic [1:0] PH_IDLE = 2'd0, PH_READ = 2'd1, PH_WRITE = 2'd2;

  logic [3:0] state;
  logic [1:0] phase;
  logic [7:0] req [6];
  logic [CW-1:0] reg_count;
  logic [15:0] crc_accum;
  logic [7:0] rx_count;
  logic [7:0] tail0, tail1;
  logic header_ok;
  logic [15:0] word_store [MAX_REGS];
  logic [7:0] high_hold;
  logic [2:0] tx_idx;
  logic [CW-1:0] drain_idx;
  logic [15:0] rd_data;
  logic [7:0] rxb;
  logic rxe;
  logic [2:0] st;
  crc_cmd_t cmd;
  logic crc_busy;
  logic [15:0] crc_val;

  mbm_crc u_crc (.clk(clk), .rst(rst), .cmd(cmd), .busy(crc_busy), .crc(crc_val));

  assign in_stall = (state != S_IDLE);
  logic acc;
  assign acc = in_valid && !in_stall;
  logic [7:0] idx_off;
  assign idx_off = rx_count - 8'd3;
  logic [6:0] wsel;
  assign wsel = idx_off[7:1];
  logic bad_count;
  assign bad_count = (func == FUNC_READ) &&
                     (word_value == 16'd0 || word_value > 16'(MAX_REGS));

  always_comb begin
    cmd = '0;
    if (state == S_TXC) begin
      cmd.start = 1'b1;
      cmd.init = (tx_idx == 3'd0) ? CRC_INIT : crc_val;
      cmd.data = req[tx_idx];
    end else if (state == S_RXC) begin
      cmd.start = 1'b1;
      cmd.init = crc_accum;
      cmd.data = tail0;
    end
  end

  logic out_valid_next;
  always_comb begin
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_IDLE: if (acc && bad_count) out_valid_next = 1'b1;
      S_TXW: if (!crc_busy) out_valid_next = 1'b1;
      S_RD, S_DOUT: if (!out_valid || !out_stall) out_valid_next = 1'b1;
      default: ;
    endcase
  end

  logic crc_good;
  assign crc_good = (rx_count >= 8'd2) && (tail0 == crc_accum[7:0]) &&
                    (tail1 == crc_accum[15:8]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IDLE;
      out_valid <= 1'b0;
      reg_count <= '0;
      crc_accum <= CRC_INIT;
      rx_count <= 8'd0;
      tail0 <= 8'd0;
      tail1 <= 8'd0;
      header_ok <= 1'b1;
      tx_idx <= 3'd0;
      drain_idx <= '0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            out_kind <= KIND_TX; out_byte <= 8'd0; out_word <= 16'd0;
            word_index <= 5'd0; status <= ST_OK; last <= 1'b0;
            if (func == FUNC_READ || func == FUNC_WRITE) begin
              if (bad_count) begin
                phase <= PH_IDLE;
                out_kind <= KIND_STATUS; status <= ST_COUNT; last <= 1'b1;
                state <= S_STAT;
              end else begin
                req[0] <= slave_addr;
                req[1] <= (func == FUNC_READ) ? FC_READ : FC_WRITE;
                req[2] <= reg_number[15:8];
                req[3] <= reg_number[7:0];
                req[4] <= word_value[15:8];
                req[5] <= word_value[7:0];
                if (func == FUNC_READ) reg_count <= word_value[CW-1:0];
                phase <= (func == FUNC_READ) ? PH_READ : PH_WRITE;
                crc_accum <= CRC_INIT;
                rx_count <= 8'd0;
                tail0 <= 8'd0;
                tail1 <= 8'd0;
                header_ok <= 1'b1;
                tx_idx <= 3'd0;
                state <= S_TXC;
              end
            end else if (func == FUNC_BYTE && phase != PH_IDLE) begin
              rxb <= rx_byte;
              rxe <= rx_end;
              state <= (rx_count >= 8'd2) ? S_RXC : S_RXW;
            end
          end
        end
        S_TXC: state <= S_TXW;
        S_TXW: if (!crc_busy) begin
          out_kind <= KIND_TX;
          if (tx_idx[2:1] == 2'b11) begin
            out_byte <= tx_idx[0] ? crc_val[15:8] : crc_val[7:0];
          end else begin
            out_byte <= req[tx_idx];
          end
          last <= (tx_idx == 3'd7);
          state <= S_TXO;
        end
        S_TXO: if (!out_valid || !out_stall) begin
          if (tx_idx == 3'd7) begin
            state <= S_STAT;
          end else begin
            tx_idx <= tx_idx + 3'd1;
            state <= (tx_idx < 3'd5) ? S_TXC : S_TXW;
          end
        end
        S_RXC: state <= S_RXW;
        S_RXW: if (!crc_busy) begin
          if (rx_count >= 8'd2) crc_accum <= crc_val;
          tail0 <= tail1;
          tail1 <= rxb;
          if (phase == PH_READ) begin
            if ((rx_count == 8'd0 && rxb != req[0]) ||
                (rx_count == 8'd1 && rxb != FC_READ)) header_ok <= 1'b0;
            if (rx_count >= 8'd3) begin
              if (!idx_off[0]) high_hold <= rxb;
              else if (wsel < 7'(MAX_REGS) && wsel < 7'(reg_count))
                word_store[wsel[AW-1:0]] <= {high_hold, rxb};
            end
          end else if (rx_count < 8'd6 && rxb != req[rx_count[2:0]]) begin
            header_ok <= 1'b0;
          end
          if (rx_count != 8'd255) rx_count <= rx_count + 8'd1;
          state <= rxe ? S_END : S_IDLE;
        end
        S_END: begin
          phase <= PH_IDLE;
          if (phase == PH_READ) begin
            if (!header_ok) st <= ST_HEADER;
            else if (rx_count < 8'd5 + {reg_count, 1'b0}) st <= ST_LENGTH;
            else if (!crc_good) st <= ST_CRC;
            else st <= ST_OK;
            drain_idx <= '0;
            state <= (header_ok && rx_count >= 8'd5 + {reg_count, 1'b0} && crc_good)
                     ? S_DRAIN : S_DOUT;
          end else begin
            if (rx_count != 8'd8) st <= ST_LENGTH;
            else if (!header_ok) st <= ST_HEADER;
            else if (!crc_good) st <= ST_CRC;
            else st <= ST_OK;
            state <= S_DOUT;
          end
        end
        S_DRAIN: begin
          rd_data <= word_store[drain_idx[AW-1:0]];
          state <= S_RD;
        end
        S_RD: if (!out_valid || !out_stall) begin
          out_kind <= KIND_WORD;
          out_word <= rd_data;
          word_index <= 5'(drain_idx);
          drain_idx <= drain_idx + 1'b1;
          state <= (drain_idx + 1'b1 == reg_count) ? S_DOUT : S_DRAIN;
        end
        S_DOUT: if (!out_valid || !out_stall) begin
          out_kind <= KIND_STATUS; out_word <= 16'd0; word_index <= 5'd0;
          status <= st; last <= 1'b1;
          state <= S_STAT;
        end
        S_STAT: if (!out_valid || !out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word) && $stable(out_kind))
    else $error("held result changed");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !crc_busy)
    else $error("crc busy while idle");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    acc |-> !out_valid || !out_stall)
    else $error("accepted with result pending");
endmodule

>>> hdl/mbm_crc.sv
// Bit-serial CRC-16/MODBUS unit that folds one byte in, one bit at a time.
module mbm_crc import mbm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  crc_cmd_t cmd,
  output logic busy,
  output logic [15:0] crc
);
  logic [7:0] sh;
  logic [2:0] cnt;
  logic [15:0] c;
  always_comb c = crc ^ {15'd0, sh[0]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      crc <= CRC_INIT;
      cnt <= 3'd0;
      sh <= 8'd0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      crc <= cmd.init;
      sh <= cmd.data;
      cnt <= 3'd0;
    end else if (busy) begin
      crc <= c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      sh <= sh >> 1;
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) busy <= 1'b0;
    end
  end
endmodule

>>> tb/tb_modbus_rtu_master_fc03_fc06.sv
// Self-checking testbench for the Modbus RTU master with FC03/FC06 requests and response checks.
module tb_modbus_rtu_master_fc03_fc06;
  import mbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REGS = 32;
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int WD_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [1:0] {PH_IDLE, PH_READ, PH_WRITE} phase_t;
  typedef enum int {RSP_GOOD, RSP_HEADER, RSP_SHORT, RSP_CRC, RSP_EXTRA} rsp_mode_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic [15:0] word;
    logic [4:0] idx;
    logic [2:0] st;
    logic fin;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = '0;
  logic [7:0] slave_addr = '0;
  logic [15:0] reg_number = '0;
  logic [15:0] word_value = '0;
  logic [7:0] rx_byte = '0;
  logic rx_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [15:0] out_word;
  logic [4:0] word_index;
  logic [2:0] status;
  logic last;

  result_t pending_results[$];
  phase_t mb_phase;
  logic [7:0] req_frame[6];
  logic [5:0] mb_count;
  logic [15:0] rsp_crc;
  logic [7:0] rsp_len;
  logic [7:0] rsp_tail[2];
  logic hdr_good;
  logic [15:0] reg_words[MAX_REGS];
  logic [7:0] hi_byte;

  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int hold_done = 0;
  int wd_count = 0;

  modbus_rtu_master_fc03_fc06 #(.MAX_REGS(MAX_REGS)) u_top (.*);

  always #5 clk = ~clk;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic push_result(logic [1:0] kind, logic [7:0] b, logic [15:0] w,
                             logic [4:0] ix, logic [2:0] st, logic fin);
    result_t r;
    r.kind = kind; r.tx_byte = b; r.word = w; r.idx = ix; r.st = st; r.fin = fin;
    pending_results.push_back(r);
  endtask

  task automatic emit_request(logic [7:0] fc, logic [7:0] addr, logic [15:0] rn,
                              logic [15:0] wv);
    logic [15:0] c;
    c = CRC_INIT;
    req_frame[0] = addr; req_frame[1] = fc;
    req_frame[2] = rn[15:8]; req_frame[3] = rn[7:0];
    req_frame[4] = wv[15:8]; req_frame[5] = wv[7:0];
    for (int i = 0; i < 6; i++) begin
      c = crc16_byte(c, req_frame[i]);
      push_result(KIND_TX, req_frame[i], '0, '0, ST_OK, 1'b0);
    end
    push_result(KIND_TX, c[7:0], '0, '0, ST_OK, 1'b0);
    push_result(KIND_TX, c[15:8], '0, '0, ST_OK, 1'b1);
    rsp_crc = CRC_INIT; rsp_len = '0; rsp_tail[0] = '0; rsp_tail[1] = '0; hdr_good = 1'b1;
  endtask

  task automatic predict_master(logic [1:0] f, logic [7:0] addr, logic [15:0] rn,
                                logic [15:0] wv, logic [7:0] b, logic e);
    int ix;
    int need;
    int off;
    logic [2:0] st;
    logic crc_ok;
    ix = int'(rsp_len);
    if (f == FUNC_READ) begin
      if (wv == 0 || wv > MAX_REGS) begin
        mb_phase = PH_IDLE;
        push_result(KIND_STATUS, '0, '0, '0, ST_COUNT, 1'b1);
      end else begin
        mb_count = wv[5:0];
        mb_phase = PH_READ;
        emit_request(FC_READ, addr, rn, wv);
      end
    end else if (f == FUNC_WRITE) begin
      mb_phase = PH_WRITE;
      emit_request(FC_WRITE, addr, rn, wv);
    end else if (f == FUNC_BYTE && mb_phase != PH_IDLE) begin
      if (ix >= 2) rsp_crc = crc16_byte(rsp_crc, rsp_tail[0]);
      rsp_tail[0] = rsp_tail[1];
      rsp_tail[1] = b;
      if (mb_phase == PH_READ) begin
        if ((ix == 0 && b != req_frame[0]) || (ix == 1 && b != FC_READ))
          hdr_good = 1'b0;
        if (ix >= 3) begin
          off = ix - 3;
          if (off % 2 == 0) hi_byte = b;
          else if (off / 2 < mb_count) reg_words[off / 2] = {hi_byte, b};
        end
      end else if (ix < 6 && b != req_frame[ix]) begin
        hdr_good = 1'b0;
      end
      if (rsp_len < 255) rsp_len++;
      if (e) begin
        crc_ok = rsp_len >= 2 && rsp_tail[0] == rsp_crc[7:0] &&
                 rsp_tail[1] == rsp_crc[15:8];
        if (mb_phase == PH_READ) begin
          need = 5 + 2 * int'(mb_count);
          if (!hdr_good) st = ST_HEADER;
          else if (int'(rsp_len) < need) st = ST_LENGTH;
          else if (!crc_ok) st = ST_CRC;
          else st = ST_OK;
          if (st == ST_OK)
            for (int i = 0; i < mb_count; i++)
              push_result(KIND_WORD, '0, reg_words[i], i[4:0], ST_OK, 1'b0);
        end else begin
          if (rsp_len != 8) st = ST_LENGTH;
          else if (!hdr_good) st = ST_HEADER;
          else if (!crc_ok) st = ST_CRC;
          else st = ST_OK;
        end
        push_result(KIND_STATUS, '0, '0, '0, st, 1'b1);
        mb_phase = PH_IDLE;
      end
    end
  endtask

  task automatic send_beat(logic [1:0] f, logic [7:0] addr, logic [15:0] rn,
                           logic [15:0] wv, logic [7:0] b, logic e);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? int'($urandom_range(4, 1)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f; slave_addr <= addr; reg_number <= rn; word_value <= wv;
    rx_byte <= b; rx_end <= e;
    do @(posedge clk); while (in_stall);
    predict_master(f, addr, rn, wv, b, e);
    beats_in++;
  endtask

  task automatic send_byte(logic [7:0] b, logic e);
    send_beat(FUNC_BYTE, 8'($urandom), 16'($urandom), 16'($urandom), b, e);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_frame(logic [7:0] fr[$], rsp_mode_t mode);
    int k;
    case (mode)
      RSP_HEADER: begin
        k = $urandom_range(1);
        fr[k] = fr[k] ^ (8'h01 << $urandom_range(7));
      end
      RSP_SHORT: begin
        k = $urandom_range(fr.size() - 1, 1);
        while (fr.size() > k) void'(fr.pop_back());
      end
      RSP_CRC: begin
        k = $urandom_range(fr.size() - 1, 2);
        fr[k] = fr[k] ^ (8'h01 << $urandom_range(7));
      end
      RSP_EXTRA: repeat ($urandom_range(3, 1)) fr.push_back(8'($urandom));
      default: ;
    endcase
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
  endtask

  function automatic void add_crc(ref logic [7:0] fr[$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (fr[i]) c = crc16_byte(c, fr[i]);
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
  endfunction

  task automatic read_transaction(logic [7:0] addr, logic [15:0] rn, int cnt,
                                  rsp_mode_t mode);
    logic [7:0] fr[$];
    logic [15:0] w;
    send_beat(FUNC_READ, addr, rn, cnt[15:0], 8'($urandom), 1'($urandom));
    fr = {addr, FC_READ, 8'(2 * cnt)};
    for (int i = 0; i < cnt; i++) begin
      w = 16'($urandom);
      if (i == 0) w = 16'hFFFF;
      if (i == 1) w = 16'h0000;
      fr.push_back(w[15:8]);
      fr.push_back(w[7:0]);
    end
    add_crc(fr);
    send_frame(fr, mode);
  endtask

  task automatic write_transaction(logic [7:0] addr, logic [15:0] rn, logic [15:0] wv,
                                   rsp_mode_t mode);
    logic [7:0] fr[$];
    send_beat(FUNC_WRITE, addr, rn, wv, 8'($urandom), 1'($urandom));
    fr = {addr, FC_WRITE, rn[15:8], rn[7:0], wv[15:8], wv[7:0]};
    if (mode == RSP_HEADER) begin
      fr[$urandom_range(5)] ^= 8'h80;
      mode = RSP_GOOD;
    end
    add_crc(fr);
    send_frame(fr, mode);
  endtask

  task automatic test_directed();
    send_beat(FUNC_READ, 8'h11, 16'h0000, 16'd0, 8'h00, 1'b0);
    send_beat(FUNC_READ, 8'h11, 16'hFFFF, 16'd33, 8'hFF, 1'b1);
    send_beat(FUNC_READ, 8'h11, 16'h1234, 16'hFFFF, 8'h00, 1'b1);
    send_byte(8'hA5, 1'b1);
    send_beat(FUNC_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    write_transaction(8'h00, 16'h0000, 16'h0000, RSP_GOOD);
    write_transaction(8'hFF, 16'hFFFF, 16'hFFFF, RSP_GOOD);
    read_transaction(8'hFF, 16'hFFFF, 1, RSP_GOOD);
    read_transaction(8'h01, 16'h0100, 2, RSP_HEADER);
    read_transaction(8'h02, 16'h0200, 2, RSP_SHORT);
    read_transaction(8'h03, 16'h0300, 2, RSP_CRC);
    read_transaction(8'h04, 16'h0400, 2, RSP_EXTRA);
    write_transaction(8'h05, 16'h0500, 16'hBEEF, RSP_HEADER);
    write_transaction(8'h06, 16'h0600, 16'hCAFE, RSP_SHORT);
    write_transaction(8'h07, 16'h0700, 16'hF00D, RSP_CRC);
    send_beat(FUNC_WRITE, 8'h08, 16'h0800, 16'h0001, 8'h00, 1'b0);
    send_byte(8'h08, 1'b0);
    read_transaction(8'h09, 16'h0900, 1, RSP_GOOD);
    wait_drained();
  endtask

  task automatic test_random(int n_beats);
    int stop_at;
    int pick;
    int cnt;
    rsp_mode_t mode;
    stop_at = beats_in + n_beats;
    while (beats_in < stop_at) begin
      pick = $urandom_range(99);
      cnt = ($urandom_range(19) == 0) ? MAX_REGS : int'($urandom_range(4, 1));
      mode = ($urandom_range(99) < 70) ? RSP_GOOD : rsp_mode_t'($urandom_range(4, 1));
      if (pick < 45) read_transaction(8'($urandom), 16'($urandom), cnt, mode);
      else if (pick < 80) write_transaction(8'($urandom), 16'($urandom), 16'($urandom),
                                            mode);
      else if (pick < 85) send_beat(FUNC_READ, 8'($urandom), 16'($urandom),
                                    ($urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, 33))),
                                    8'($urandom), 1'($urandom));
      else if (pick < 90) send_byte(8'($urandom), 1'($urandom));
      else if (pick < 94) send_beat(FUNC_NONE, 8'($urandom), 16'($urandom), 16'($urandom),
                                    8'($urandom), 1'($urandom));
      else begin
        send_beat(2'($urandom_range(1)), 8'($urandom), 16'($urandom),
                  16'($urandom_range(3, 1)), 8'd0, 1'b0);
        repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_len = HOLD_CYCLES;
    read_transaction(8'h2A, 16'h4000, MAX_REGS, RSP_GOOD);
    write_transaction(8'h2B, 16'h4001, 16'h5555, RSP_GOOD);
    wait_drained();
  endtask

  always @(posedge clk) begin
    result_t r;
    if (!rst && out_valid && !out_stall) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        report("unexpected result kind", 32'(out_kind), '0);
      end else begin
        r = pending_results.pop_front();
        if (out_kind !== r.kind) report("out_kind", 32'(out_kind), 32'(r.kind));
        if (out_byte !== r.tx_byte) report("out_byte", 32'(out_byte), 32'(r.tx_byte));
        if (out_word !== r.word) report("out_word", 32'(out_word), 32'(r.word));
        if (word_index !== r.idx) report("word_index", 32'(word_index), 32'(r.idx));
        if (status !== r.st) report("status", 32'(status), 32'(r.st));
        if (last !== r.fin) report("last", 32'(last), 32'(r.fin));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_done < hold_len) begin
      hold_done++;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) wd_count <= 0;
    else wd_count <= wd_count + 1;
    if (wd_count > WD_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    mb_phase = PH_IDLE;
    mb_count = '0;
    rsp_crc = CRC_INIT;
    rsp_len = '0;
    rsp_tail[0] = '0;
    rsp_tail[1] = '0;
    hdr_good = 1'b1;
    hi_byte = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 13; recv_idle_pct = 60;
    test_directed();
    test_random(25);
    test_backpressure();
    send_idle_pct = 60; recv_idle_pct = 13;
    test_random(25);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(25);
    $display("Covered FC03/FC06 requests, bad counts, header, length and CRC faults,");
    $display("abandoned and stray beats: %0d input beats, %0d result beats.",
             beats_in, beats_out);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
